// ===== src/bzf_pkg.sv =====
package bzf_pkg;

    localparam int MAX_LEVELS = 6;
    localparam int COORD_BITS = 32;
    localparam int NUM_COORDS = 8;
    localparam int AXES       = 2;
    localparam int CFG_W      = 3;
    localparam int FIFO_DEPTH = 2;

    localparam int LEVEL_BITS = $clog2(MAX_LEVELS + 1);
    localparam int STK_AW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_W-1:0]      DEPTH_RESET = CFG_W'(5);
    localparam logic [CFG_W-1:0]      DEPTH_LIMIT = CFG_W'(MAX_LEVELS);
    localparam logic [LEVEL_BITS-1:0] LEVEL_LIMIT = LEVEL_BITS'(MAX_LEVELS);

    // point k keeps x at index 2k and y at index 2k+1
    typedef logic [NUM_COORDS-1:0][COORD_BITS-1:0] bzf_coords_t;

    typedef struct packed {
        bzf_coords_t           coords;
        logic [LEVEL_BITS-1:0] depth;
    } bzf_item_t;

    typedef struct packed {
        logic                  busy;
        logic [LEVEL_BITS-1:0] sp;
        logic [LEVEL_BITS-1:0] level;
        logic [LEVEL_BITS-1:0] depth;
    } bzf_status_t;

    // floor((a + b) / 2) on the exact sum
    function automatic logic [COORD_BITS-1:0] half_sum(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        return s[COORD_BITS:1];
    endfunction

endpackage

// ===== src/bzf_front.sv =====
module bzf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bzf_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bzf_pkg::bzf_coords_t              in_coords,
    output logic                              push_valid,
    input  logic                              push_ready,
    output bzf_pkg::bzf_item_t                push_item
);

    logic [bzf_pkg::CFG_W-1:0]      max_depth_reg;
    logic [bzf_pkg::CFG_W-1:0]      max_depth_next;
    logic                           hold_valid_reg;
    logic                           hold_valid_next;
    bzf_pkg::bzf_item_t             hold_item_reg;
    logic [bzf_pkg::LEVEL_BITS-1:0] depth_sat;
    logic                           in_beat;

    assign cfg_ready = 1'b1;
    assign in_ready  = !hold_valid_reg || push_ready;
    assign in_beat   = in_valid && in_ready;

    // depths past the stack size saturate
    assign depth_sat = (max_depth_reg > bzf_pkg::DEPTH_LIMIT)
                     ? bzf_pkg::LEVEL_LIMIT
                     : max_depth_reg[bzf_pkg::LEVEL_BITS-1:0];

    always_comb
    begin
        max_depth_next = cfg_valid ? cfg_data : max_depth_reg;
        if (in_beat)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg  <= bzf_pkg::DEPTH_RESET;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            max_depth_reg  <= max_depth_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            hold_item_reg.coords <= in_coords;
            hold_item_reg.depth  <= depth_sat;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

endmodule

// ===== src/bzf_fifo.sv =====
module bzf_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  bzf_pkg::bzf_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output bzf_pkg::bzf_item_t pop_item
);

    bzf_pkg::bzf_item_t              mem [bzf_pkg::FIFO_DEPTH];
    logic [bzf_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [bzf_pkg::FIFO_AW-1:0]     wr_ptr_next;
    logic [bzf_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [bzf_pkg::FIFO_AW-1:0]     rd_ptr_next;
    logic [bzf_pkg::FIFO_CW-1:0]     count_reg;
    logic [bzf_pkg::FIFO_CW-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != bzf_pkg::FIFO_CW'(bzf_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == bzf_pkg::FIFO_AW'(bzf_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == bzf_pkg::FIFO_AW'(bzf_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/bzf_back.sv =====
module bzf_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  bzf_pkg::bzf_item_t                 item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bzf_pkg::COORD_BITS-1:0]     out_x,
    output logic [bzf_pkg::COORD_BITS-1:0]     out_y,
    output logic                               out_last,
    output bzf_pkg::bzf_status_t               status
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SPLIT_A = 5'b00010,
        ST_SPLIT_B = 5'b00100,
        ST_SPLIT_C = 5'b01000,
        ST_EMIT    = 5'b10000
    } bzf_state_t;

    typedef logic [bzf_pkg::AXES-1:0][bzf_pkg::COORD_BITS-1:0] axis_pair_t;

    bzf_state_t                        state_reg;
    bzf_state_t                        state_next;
    logic [bzf_pkg::LEVEL_BITS-1:0]    sp_reg;
    logic [bzf_pkg::LEVEL_BITS-1:0]    sp_next;
    logic [bzf_pkg::LEVEL_BITS-1:0]    level_reg;
    logic [bzf_pkg::LEVEL_BITS-1:0]    level_next;
    logic [bzf_pkg::LEVEL_BITS-1:0]    depth_reg;
    logic [bzf_pkg::LEVEL_BITS-1:0]    depth_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;

    bzf_pkg::bzf_coords_t              cur_reg;
    axis_pair_t                        l2_reg;
    axis_pair_t                        h_reg;
    axis_pair_t                        r3_reg;
    axis_pair_t                        l3_reg;
    axis_pair_t                        r2_reg;
    bzf_pkg::bzf_coords_t              stack_mem [bzf_pkg::MAX_LEVELS];
    logic [bzf_pkg::LEVEL_BITS-1:0]    lvl_mem [bzf_pkg::MAX_LEVELS];
    logic [bzf_pkg::COORD_BITS-1:0]    out_x_reg;
    logic [bzf_pkg::COORD_BITS-1:0]    out_y_reg;
    logic                              out_last_reg;

    axis_pair_t                        a_l2;
    axis_pair_t                        a_h;
    axis_pair_t                        a_r3;
    axis_pair_t                        b_l3;
    axis_pair_t                        b_r2;
    axis_pair_t                        c_mid;
    logic [bzf_pkg::LEVEL_BITS-1:0]    level_inc;
    logic [bzf_pkg::LEVEL_BITS-1:0]    sp_dec;
    logic [bzf_pkg::STK_AW-1:0]        push_idx;
    logic [bzf_pkg::STK_AW-1:0]        pop_idx;
    logic [bzf_pkg::LEVEL_BITS-1:0]    pop_level;
    logic                              emit_go;
    logic                              load_go;

    assign item_ready = (state_reg == ST_IDLE);
    assign load_go    = item_valid && item_ready;
    assign emit_go    = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign level_inc  = level_reg + 1'b1;
    assign sp_dec     = sp_reg - 1'b1;
    assign push_idx   = sp_reg[bzf_pkg::STK_AW-1:0];
    assign pop_idx    = sp_dec[bzf_pkg::STK_AW-1:0];
    assign pop_level  = lvl_mem[pop_idx];

    // three halving steps of one split, one step per cycle
    always_comb
    begin
        for (int c = 0; c < bzf_pkg::AXES; c++)
        begin
            a_l2[c]  = bzf_pkg::half_sum(cur_reg[c], cur_reg[2 + c]);
            a_h[c]   = bzf_pkg::half_sum(cur_reg[2 + c], cur_reg[4 + c]);
            a_r3[c]  = bzf_pkg::half_sum(cur_reg[4 + c], cur_reg[6 + c]);
            b_l3[c]  = bzf_pkg::half_sum(l2_reg[c], h_reg[c]);
            b_r2[c]  = bzf_pkg::half_sum(r3_reg[c], h_reg[c]);
            c_mid[c] = bzf_pkg::half_sum(l3_reg[c], r2_reg[c]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        level_next = level_reg;
        depth_next = depth_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    depth_next = item.depth;
                    level_next = '0;
                    sp_next    = '0;
                    state_next = (item.depth != '0) ? ST_SPLIT_A : ST_EMIT;
                end
            end
            ST_SPLIT_A:
            begin
                state_next = ST_SPLIT_B;
            end
            ST_SPLIT_B:
            begin
                state_next = ST_SPLIT_C;
            end
            ST_SPLIT_C:
            begin
                level_next = level_inc;
                sp_next    = sp_reg + 1'b1;
                state_next = (level_inc < depth_reg) ? ST_SPLIT_A : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    if (sp_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sp_next    = sp_dec;
                        level_next = pop_level;
                        state_next = (pop_level < depth_reg) ? ST_SPLIT_A : ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            level_reg     <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            level_reg     <= level_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, deferred-half stack and output register
    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            cur_reg <= item.coords;
        end
        if (state_reg == ST_SPLIT_A)
        begin
            l2_reg <= a_l2;
            h_reg  <= a_h;
            r3_reg <= a_r3;
        end
        if (state_reg == ST_SPLIT_B)
        begin
            l3_reg <= b_l3;
            r2_reg <= b_r2;
        end
        if (state_reg == ST_SPLIT_C)
        begin
            for (int c = 0; c < bzf_pkg::AXES; c++)
            begin
                stack_mem[push_idx][c]     <= c_mid[c];
                stack_mem[push_idx][2 + c] <= r2_reg[c];
                stack_mem[push_idx][4 + c] <= r3_reg[c];
                stack_mem[push_idx][6 + c] <= cur_reg[6 + c];
                cur_reg[2 + c]             <= l2_reg[c];
                cur_reg[4 + c]             <= l3_reg[c];
                cur_reg[6 + c]             <= c_mid[c];
            end
            lvl_mem[push_idx] <= level_inc;
        end
        if (emit_go)
        begin
            out_x_reg    <= bzf_pkg::half_sum(cur_reg[0], cur_reg[6]);
            out_y_reg    <= bzf_pkg::half_sum(cur_reg[1], cur_reg[7]);
            out_last_reg <= (sp_reg == '0);
            if (sp_reg != '0)
            begin
                cur_reg <= stack_mem[pop_idx];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_last     = out_last_reg;

    assign status.busy  = (state_reg != ST_IDLE);
    assign status.sp    = sp_reg;
    assign status.level = level_reg;
    assign status.depth = depth_reg;

endmodule

// ===== src/cubic_bezier_subdivision_flattener.sv =====
// Cubic Bezier flattener: each input beat is one curve (four Q24.8 control points), and
// the block returns 2^d polyline points in curve order, where d is max_depth saturated
// to 6 (reset value 5); each point is the midpoint of a leaf's end points after uniform
// de Casteljau halving, the last point of a curve carries final_point, and every halving
// is floor((a+b)/2) on the exact sum. The engine takes a new curve only while idle, once
// it has emitted the last point of the one before: each of the 2^d - 1 splits runs three
// dependent halving steps, one per cycle, and each point leaves through the output
// register; a stalled receiver holds the engine on its current point. The input
// register and a two-entry queue behind it hold up to three further curves, so input
// beats keep flowing while a curve is being flattened.
// max_depth is taken when a curve enters, so write it only while the block is idle.
module cubic_bezier_subdivision_flattener (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration: max_depth
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bzf_pkg::CFG_W-1:0]              cfg_data,
    // curve input
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [bzf_pkg::COORD_BITS-1:0]  start_x,
    input  logic signed [bzf_pkg::COORD_BITS-1:0]  start_y,
    input  logic signed [bzf_pkg::COORD_BITS-1:0]  ctrl_a_x,
    input  logic signed [bzf_pkg::COORD_BITS-1:0]  ctrl_a_y,
    input  logic signed [bzf_pkg::COORD_BITS-1:0]  ctrl_b_x,
    input  logic signed [bzf_pkg::COORD_BITS-1:0]  ctrl_b_y,
    input  logic signed [bzf_pkg::COORD_BITS-1:0]  finish_x,
    input  logic signed [bzf_pkg::COORD_BITS-1:0]  finish_y,
    // polyline output
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [bzf_pkg::COORD_BITS-1:0]  point_x,
    output logic signed [bzf_pkg::COORD_BITS-1:0]  point_y,
    output logic                                   final_point
);

    bzf_pkg::bzf_coords_t   in_coords;
    logic                   push_valid;
    logic                   push_ready;
    bzf_pkg::bzf_item_t     push_item;
    logic                   pop_valid;
    logic                   pop_ready;
    bzf_pkg::bzf_item_t     pop_item;
    bzf_pkg::bzf_status_t   back_status;

    // pack control points, x at even index, y at odd
    assign in_coords[0] = start_x;
    assign in_coords[1] = start_y;
    assign in_coords[2] = ctrl_a_x;
    assign in_coords[3] = ctrl_a_y;
    assign in_coords[4] = ctrl_b_x;
    assign in_coords[5] = ctrl_b_y;
    assign in_coords[6] = finish_x;
    assign in_coords[7] = finish_y;

    // input stage: takes the beat, holds max_depth, saturates the depth
    bzf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_coords  (in_coords),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // short queue of pending curves
    bzf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // subdivision engine with deferred-half stack and output register
    bzf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item       (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_x      (point_x),
        .out_y      (point_y),
        .out_last   (final_point),
        .status     (back_status)
    );

`ifndef SYNTHESIS
    // never split past the configured depth
    a_level_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.level <= back_status.depth)
        else $error("subdivision level beyond depth");

    // deferred halves never outnumber the current level
    a_sp_in_level: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.sp <= back_status.level)
        else $error("stack pointer beyond level");

    // a new output beat only comes from an active curve
    a_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(back_status.busy))
        else $error("output beat while engine idle");
`endif

endmodule
